// File: rtl/atws_pkg.sv
// Package for the a-trous wavelet sharpening block.
// Holds the sequencer state type, request mode codes and register indexes.
// No dependencies.
package atws_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LAYERS = 3'd2;
  localparam logic [2:0] REG_GAIN0  = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ_RD,
    ST_READ_MUL,
    ST_READ_OUT,
    ST_CLR,
    ST_TAP_RD,
    ST_TAP_ACC,
    ST_PIX_WR,
    ST_DET_RD,
    ST_DET_MUL,
    ST_DET_WR
  } state_t;

endpackage

// File: rtl/a_trous_wavelet_sharpen.sv
// Top level of the a-trous B3-spline wavelet sharpening block.
// A load writes its pixel in the LOAD state; a read passes through READ_RD, READ_MUL and READ_OUT
// before its result is valid, and frees the input in the cycle after the result is taken.
// A run clears the detail sums, then per layer runs a horizontal, a vertical and a detail pass, with
// one shared tap accumulator that reads one memory word per tap in a read and an accumulate state.
// Synchronous active-low reset restores the config registers, the output valid and the sequencer; memories need loads.
module a_trous_wavelet_sharpen #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_LAYERS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0], pixel_value[17:2], pixel_x[25:18], pixel_y[33:26], zero fill
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_value[15:0]
  output logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [8:0]  width_r, height_r;
  logic [2:0]  layers_r;
  logic [15:0] gain_r [5];

  logic [25:0] approx_mem [DEPTH];
  logic [25:0] row_mem    [DEPTH];
  logic [25:0] next_mem   [DEPTH];
  logic [31:0] sum_mem    [DEPTH];

  atws_pkg::state_t state_r, state_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [2:0]  tap_r, tap_nxt;
  logic [2:0]  layer_r, layer_nxt;
  logic        vert_r, vert_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [47:0] prod_r, prod_nxt;
  logic [15:0] pix_r, pix_nxt;
  logic        inside_r, inside_nxt;
  logic [15:0] out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic [25:0] rd_a_r, rd_row_r, rd_next_r;
  logic [31:0] rd_sum_r;

  // Effective sizes.
  logic [12:0] w_eff, h_eff;
  logic [2:0]  l_eff;
  always_comb begin
    w_eff = (width_r == 9'd0) ? 13'd1 :
            ({4'd0, width_r} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, width_r};
    h_eff = (height_r == 9'd0) ? 13'd1 :
            ({4'd0, height_r} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, height_r};
    l_eff = (32'(layers_r) > MAX_LAYERS) ? 3'(MAX_LAYERS) : layers_r;
  end

  // Tap coordinate with edge clamp.
  logic signed [14:0] off, coord, lim;
  logic [AW-1:0] tap_addr, pix_addr;
  logic [3:0]  kw;
  always_comb begin
    off = 15'(($signed({1'b0, tap_r}) - 15'sd2) <<< layer_r);
    lim = vert_r ? $signed({2'b0, h_eff}) - 15'sd1 : $signed({2'b0, w_eff}) - 15'sd1;
    coord = (vert_r ? $signed({{(15-YW){1'b0}}, y_r}) : $signed({{(15-XW){1'b0}}, x_r}))
            + off;
    if (coord < 0) coord = '0;
    if (coord > lim) coord = lim;
    tap_addr = vert_r ? {YW'(coord), x_r} : {y_r, XW'(coord)};
    pix_addr = {y_r, x_r};
    case (tap_r)
      3'd0, 3'd4: kw = 4'd1;
      3'd1, 3'd3: kw = 4'd4;
      default:    kw = 4'd6;
    endcase
  end

  logic [7:0] in_x, in_y;
  logic       in_inside;
  assign in_x = in_tdata[25:18];
  assign in_y = in_tdata[33:26];
  assign in_inside = (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);

  logic last_x, last_y;
  assign last_x = (13'(x_r) == w_eff - 13'd1);
  assign last_y = (13'(y_r) == h_eff - 13'd1);

  logic signed [31:0] tap_val;
  assign tap_val = vert_r ? 32'($signed(rd_row_r)) : 32'($signed(rd_a_r));

  // Round acc/16 and saturate to 26 bits.
  logic signed [31:0] rsum;
  logic signed [27:0] rq;
  logic [25:0] filt;
  always_comb begin
    rsum = acc_r + 32'sd8;
    rq   = 28'(rsum >>> 4);
    if (rq > 28'sd33554431) filt = 26'h1FFFFFF;
    else if (rq < -28'sd33554432) filt = 26'h2000000;
    else filt = rq[25:0];
  end

  // Detail accumulation, and the clamped approximation plus detail sum for reads.
  logic signed [36:0] dsum;
  logic [31:0] dsat;
  logic signed [33:0] rvsum;
  logic [24:0] rvcl;
  logic signed [47:0] rnd;
  always_comb begin
    rnd  = prod_r + 48'sd2048;
    dsum = 37'($signed(rd_sum_r)) + 37'(rnd >>> 12);
    if (dsum > 37'sd2147483647) dsat = 32'h7FFFFFFF;
    else if (dsum < -37'sd2147483648) dsat = 32'h80000000;
    else dsat = dsum[31:0];
    rvsum = 34'($signed(rd_a_r)) + 34'($signed(rd_sum_r));
    if (rvsum < 0) rvcl = '0;
    else if (rvsum > 34'sd16777216) rvcl = 25'd16777216;
    else rvcl = rvsum[24:0];
  end

  // Load conversion: round(pv * 2^24 / 65535) = pv*256 + ((pv*256 + 32768) >> 16).
  logic [25:0] load_q;
  logic [25:0] load_t;
  always_comb begin
    load_t = 26'({pix_r, 8'd0}) + 26'd32768;
    load_q = 26'({pix_r, 8'd0}) + 26'(load_t[25:16]);
  end

  logic we_approx, we_sum_clr, we_row, we_next, we_det, we_load;
  logic rd_en;
  logic [AW-1:0] rd_addr, io_addr;
  assign io_addr = {y_r, x_r};

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; y_nxt = y_r; tap_nxt = tap_r; layer_nxt = layer_r; vert_nxt = vert_r;
    acc_nxt = acc_r; prod_nxt = prod_r; pix_nxt = pix_r;
    inside_nxt = inside_r; out_nxt = out_r; ov_nxt = ov_r;
    we_load = 1'b0; we_sum_clr = 1'b0; we_row = 1'b0; we_next = 1'b0; we_det = 1'b0;
    we_approx = 1'b0; rd_en = 1'b0; rd_addr = pix_addr;
    in_tready = (state_r == atws_pkg::ST_IDLE) && !ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      atws_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          pix_nxt = in_tdata[17:2];
          inside_nxt = in_inside;
          x_nxt = XW'(in_x);
          y_nxt = YW'(in_y);
          case (atws_pkg::mode_t'(in_tdata[1:0]))
            atws_pkg::MODE_LOAD: state_nxt = atws_pkg::ST_LOAD;
            atws_pkg::MODE_READ: state_nxt = atws_pkg::ST_READ_RD;
            atws_pkg::MODE_RUN: begin
              x_nxt = '0; y_nxt = '0; layer_nxt = '0; vert_nxt = 1'b0;
              tap_nxt = '0; acc_nxt = '0;
              state_nxt = atws_pkg::ST_CLR;
            end
            default: state_nxt = atws_pkg::ST_IDLE;
          endcase
        end
      end
      atws_pkg::ST_LOAD: begin
        we_load = inside_r;
        state_nxt = atws_pkg::ST_IDLE;
      end
      atws_pkg::ST_READ_RD: begin
        rd_en = 1'b1; rd_addr = io_addr;
        state_nxt = atws_pkg::ST_READ_MUL;
      end
      atws_pkg::ST_READ_MUL: begin
        prod_nxt = 48'(rvcl) * 48'sd65535 + 48'sd8388608;
        state_nxt = atws_pkg::ST_READ_OUT;
      end
      atws_pkg::ST_READ_OUT: begin
        out_nxt = inside_r ? prod_r[39:24] : 16'd0;
        ov_nxt = 1'b1;
        state_nxt = atws_pkg::ST_IDLE;
      end
      atws_pkg::ST_CLR: begin
        we_sum_clr = 1'b1;
        if (last_x) begin
          x_nxt = '0;
          if (last_y) begin
            y_nxt = '0;
            state_nxt = (l_eff == 3'd0) ? atws_pkg::ST_IDLE : atws_pkg::ST_TAP_RD;
          end else y_nxt = y_r + 1'b1;
        end else x_nxt = x_r + 1'b1;
      end
      atws_pkg::ST_TAP_RD: begin
        rd_en = 1'b1; rd_addr = tap_addr;
        state_nxt = atws_pkg::ST_TAP_ACC;
      end
      atws_pkg::ST_TAP_ACC: begin
        acc_nxt = acc_r + tap_val * $signed({1'b0, kw});
        if (tap_r == 3'd4) begin
          tap_nxt = '0;
          state_nxt = atws_pkg::ST_PIX_WR;
        end else begin
          tap_nxt = tap_r + 1'b1;
          state_nxt = atws_pkg::ST_TAP_RD;
        end
      end
      atws_pkg::ST_PIX_WR: begin
        we_row = !vert_r; we_next = vert_r;
        acc_nxt = '0;
        state_nxt = atws_pkg::ST_TAP_RD;
        if (last_x) begin
          x_nxt = '0;
          if (last_y) begin
            y_nxt = '0;
            if (vert_r) begin
              vert_nxt = 1'b0;
              state_nxt = atws_pkg::ST_DET_RD;
            end else vert_nxt = 1'b1;
          end else y_nxt = y_r + 1'b1;
        end else x_nxt = x_r + 1'b1;
      end
      atws_pkg::ST_DET_RD: begin
        rd_en = 1'b1;
        state_nxt = atws_pkg::ST_DET_MUL;
      end
      atws_pkg::ST_DET_MUL: begin
        prod_nxt = 48'($signed(gain_r[layer_r])) *
                   48'(34'($signed(rd_a_r)) - 34'($signed(rd_next_r)));
        state_nxt = atws_pkg::ST_DET_WR;
      end
      atws_pkg::ST_DET_WR: begin
        we_det = 1'b1; we_approx = 1'b1;
        state_nxt = atws_pkg::ST_DET_RD;
        if (last_x) begin
          x_nxt = '0;
          if (last_y) begin
            y_nxt = '0;
            if (layer_r + 3'd1 >= l_eff) state_nxt = atws_pkg::ST_IDLE;
            else begin
              layer_nxt = layer_r + 3'd1;
              state_nxt = atws_pkg::ST_TAP_RD;
            end
          end else y_nxt = y_r + 1'b1;
        end else x_nxt = x_r + 1'b1;
      end
      default: state_nxt = atws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r    <= approx_mem[rd_addr];
      rd_row_r  <= row_mem[rd_addr];
      rd_next_r <= next_mem[rd_addr];
      rd_sum_r  <= sum_mem[rd_addr];
    end
    if (we_load) approx_mem[io_addr] <= load_q;
    else if (we_approx) approx_mem[pix_addr] <= rd_next_r;
    if (we_load || we_sum_clr) sum_mem[pix_addr] <= '0;
    else if (we_det) sum_mem[pix_addr] <= dsat;
    if (we_row) row_mem[pix_addr] <= filt;
    if (we_next) next_mem[pix_addr] <= filt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atws_pkg::ST_IDLE;
      ov_r <= 1'b0;
      width_r <= 9'd256; height_r <= 9'd256; layers_r <= 3'd3;
      for (int i = 0; i < 5; i++) gain_r[i] <= 16'd4096;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          atws_pkg::REG_WIDTH:  width_r <= cfg_data[8:0];
          atws_pkg::REG_HEIGHT: height_r <= cfg_data[8:0];
          atws_pkg::REG_LAYERS: layers_r <= cfg_data[2:0];
          default: gain_r[3'(cfg_index - atws_pkg::REG_GAIN0)] <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; tap_r <= tap_nxt; layer_r <= layer_nxt;
    vert_r <= vert_nxt; acc_r <= acc_nxt; prod_r <= prod_nxt; pix_r <= pix_nxt;
    inside_r <= inside_nxt; out_r <= out_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

endmodule

// File: rtl/atws_checker.sv
// Port checker for the a-trous wavelet sharpening block.
// Depends on atws_pkg and on a_trous_wavelet_sharpen, to which it is bound.
module atws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // The block never takes a request while a result waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request accepted while result pending");

  // An accepted request with a used mode makes the block busy in the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] != atws_pkg::MODE_NONE |=> !in_tready)
    else $error("ready right after accepted request");

  // Load requests give no result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == atws_pkg::MODE_LOAD |=> ##1 !out_tvalid)
    else $error("result after load request");

endmodule

bind a_trous_wavelet_sharpen atws_checker u_atws_checker (.*);

// File: tb/sv/tb_a_trous_wavelet_sharpen.sv
// Testbench for the a-trous wavelet sharpening block: loads, runs and reads
// pixels through the stream ports and checks every read against a predictor.
// Depends on atws_pkg and a_trous_wavelet_sharpen.
`timescale 1ns / 100ps

class sharpen_scoreboard;
  int approx[65536];
  int row_pass[65536];
  int next_approx[65536];
  int sum[65536];
  bit loaded[65536];
  int loaded_list[$];
  logic [15:0] exp_pixels[$];
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  logic [2:0] layers_reg;
  logic signed [15:0] gain[5];
  int errors;

  function new();
    width_reg = 9'd256;
    height_reg = 9'd256;
    layers_reg = 3'd3;
    for (int j = 0; j < 5; j++) gain[j] = 16'sd4096;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      atws_pkg::REG_WIDTH: width_reg = data[8:0];
      atws_pkg::REG_HEIGHT: height_reg = data[8:0];
      atws_pkg::REG_LAYERS: layers_reg = data[2:0];
      default: begin
        if (idx >= atws_pkg::REG_GAIN0) gain[idx - atws_pkg::REG_GAIN0] = data;
      end
    endcase
  endfunction

  function longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function int sat26(longint v);
    if (v < -(longint'(1) << 25)) return -(1 << 25);
    if (v > (longint'(1) << 25) - 1) return (1 << 25) - 1;
    return int'(v);
  endfunction

  function void sharpen_image();
    int w, h, layers, stp, i, k, a;
    longint acc, g, s;
    w = (width_reg == 0) ? 1 : ((width_reg > 256) ? 256 : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > 256) ? 256 : height_reg);
    layers = (layers_reg > 5) ? 5 : layers_reg;
    stp = 1;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) sum[y * 256 + x] = 0;
    for (int j = 0; j < layers; j++) begin
      g = gain[j];
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          acc = 0;
          for (int t = -2; t <= 2; t++) begin
            i = x + t * stp;
            i = (i < 0) ? 0 : ((i > w - 1) ? w - 1 : i);
            k = (t == 0) ? 6 : ((t == 1 || t == -1) ? 4 : 1);
            acc += k * longint'(approx[y * 256 + i]);
          end
          row_pass[y * 256 + x] = sat26(rnd_shift(acc, 4));
        end
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          acc = 0;
          for (int t = -2; t <= 2; t++) begin
            i = y + t * stp;
            i = (i < 0) ? 0 : ((i > h - 1) ? h - 1 : i);
            k = (t == 0) ? 6 : ((t == 1 || t == -1) ? 4 : 1);
            acc += k * longint'(row_pass[i * 256 + x]);
          end
          next_approx[y * 256 + x] = sat26(rnd_shift(acc, 4));
        end
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          a = y * 256 + x;
          s = longint'(sum[a]) + rnd_shift(g * (longint'(approx[a]) - next_approx[a]), 12);
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          sum[a] = int'(s);
          approx[a] = next_approx[a];
        end
      stp *= 2;
    end
  endfunction

  function void note_request(atws_pkg::mode_t m, logic [15:0] pv, logic [7:0] x,
                             logic [7:0] y);
    int a;
    longint v;
    a = int'(y) * 256 + int'(x);
    case (m)
      atws_pkg::MODE_LOAD: begin
        approx[a] = int'(((longint'(pv) << 24) + 32767) / 65535);
        sum[a] = 0;
        if (!loaded[a]) begin
          loaded[a] = 1;
          loaded_list.push_back(a);
        end
      end
      atws_pkg::MODE_RUN: sharpen_image();
      atws_pkg::MODE_READ: begin
        v = longint'(approx[a]) + sum[a];
        if (v < 0) v = 0;
        if (v > (longint'(1) << 24)) v = longint'(1) << 24;
        exp_pixels.push_back(16'((v * 65535 + (longint'(1) << 23)) >> 24));
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [15:0] act);
    logic [15:0] exp_v;
    if (exp_pixels.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0d", $time, act);
      errors++;
    end else begin
      exp_v = exp_pixels.pop_front();
      if (act !== exp_v) begin
        $display("%0t: result_value expected %0d actual %0d", $time, exp_v, act);
        errors++;
      end
    end
  endfunction
endclass

module tb_a_trous_wavelet_sharpen;

  localparam int IDLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;
  logic cfg_wr_en;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  sharpen_scoreboard sb;
  bit idle_en;
  int n_requests;
  int idle_cycles;

  a_trous_wavelet_sharpen u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("a_trous_wavelet_sharpen test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(atws_pkg::mode_t m, logic [15:0] pv, logic [7:0] x,
                              logic [7:0] y);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, y, x, pv, m};
    do @(posedge clk); while (!in_tready);
    sb.note_request(m, pv, x, y);
    n_requests++;
    if (n_requests > 1400) idle_en = 1'b0;
  endtask

  task automatic read_random();
    int a;
    a = sb.loaded_list[$urandom_range(0, sb.loaded_list.size() - 1)];
    send_request(atws_pkg::MODE_READ, 16'($urandom), 8'(a % 256), 8'(a / 256));
  endtask

  task automatic settle_block();
    if (sb.loaded_list.size() > 0) read_random();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.exp_pixels.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain(bit extreme);
    int r;
    r = $urandom_range(0, 5);
    if (extreme || r == 0) return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
    if (r == 1) return 16'd4096;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic do_phase(int wr, int hr, int lay, int n_reads, bit gain_ext);
    int we, he;
    settle_block();
    write_reg(atws_pkg::REG_WIDTH, 16'(wr));
    write_reg(atws_pkg::REG_HEIGHT, 16'(hr));
    write_reg(atws_pkg::REG_LAYERS, 16'(lay));
    for (int j = 0; j < 5; j++) write_reg(atws_pkg::REG_GAIN0 + 3'(j), pick_gain(gain_ext));
    we = (wr == 0) ? 1 : ((wr > 256) ? 256 : wr);
    he = (hr == 0) ? 1 : ((hr > 256) ? 256 : hr);
    for (int y = 0; y < he; y++)
      for (int x = 0; x < we; x++)
        send_request(atws_pkg::MODE_LOAD, pick_pixel(), 8'(x), 8'(y));
    repeat ($urandom_range(0, 3))
      send_request(atws_pkg::MODE_LOAD, 16'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_request(atws_pkg::MODE_NONE, 16'($urandom), 8'($urandom), 8'($urandom));
    read_random();
    send_request(atws_pkg::MODE_RUN, 16'($urandom), 8'($urandom), 8'($urandom));
    repeat (n_reads) read_random();
    if ($urandom_range(0, 1) != 0) begin
      send_request(atws_pkg::MODE_RUN, 16'($urandom), 8'($urandom), 8'($urandom));
      repeat (n_reads) read_random();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_en = 1'b1;
    n_requests = 0;
    idle_cycles = 0;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Small image, zero layers, extreme pixels and the far corner address.
    write_reg(atws_pkg::REG_WIDTH, 16'd3);
    write_reg(atws_pkg::REG_HEIGHT, 16'd2);
    write_reg(atws_pkg::REG_LAYERS, 16'd0);
    send_request(atws_pkg::MODE_LOAD, 16'd0, 8'd0, 8'd0);
    send_request(atws_pkg::MODE_LOAD, 16'hffff, 8'd1, 8'd0);
    send_request(atws_pkg::MODE_LOAD, 16'd1, 8'd2, 8'd0);
    send_request(atws_pkg::MODE_LOAD, 16'h8000, 8'd0, 8'd1);
    send_request(atws_pkg::MODE_LOAD, 16'hfffe, 8'd1, 8'd1);
    send_request(atws_pkg::MODE_LOAD, 16'd12345, 8'd2, 8'd1);
    send_request(atws_pkg::MODE_LOAD, 16'hffff, 8'd255, 8'd255);
    send_request(atws_pkg::MODE_READ, 16'hffff, 8'd1, 8'd0);
    send_request(atws_pkg::MODE_READ, 16'd0, 8'd0, 8'd0);
    send_request(atws_pkg::MODE_READ, 16'd0, 8'd255, 8'd255);
    send_request(atws_pkg::MODE_NONE, 16'hffff, 8'd255, 8'd255);
    send_request(atws_pkg::MODE_RUN, 16'd0, 8'd0, 8'd0);
    send_request(atws_pkg::MODE_READ, 16'd0, 8'd2, 8'd1);
    send_request(atws_pkg::MODE_READ, 16'd0, 8'd255, 8'd255);

    // Out of range and edge sizes and layer counts, extreme gains in the first three phases.
    do_phase(0, 0, 7, 3, 1'b1);
    do_phase(511, 1, 5, 6, 1'b1);
    do_phase(1, 300, 6, 6, 1'b1);
    do_phase(256, 2, 5, 4, 1'b0);

    while (n_requests < 1550) begin
      if ($urandom_range(0, 7) == 0) begin
        do_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 7),
                 $urandom_range(5, 15), 1'b0);
      end else begin
        do_phase($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 7),
                 $urandom_range(5, 15), 1'b0);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.exp_pixels.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.exp_pixels.size() == 0) begin
      $display("a_trous_wavelet_sharpen test passed");
    end else begin
      $display("a_trous_wavelet_sharpen test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/atws_pkg.sv
rtl/a_trous_wavelet_sharpen.sv
rtl/atws_checker.sv
tb/sv/tb_a_trous_wavelet_sharpen.sv
